>>> hw/rtl/lowpass_echo_audio_effect_assert.svh
// Assertion macros used by the lowpass echo effect RTL.
`ifndef LOWPASS_ECHO_AUDIO_EFFECT_ASSERT_SVH
`define LOWPASS_ECHO_AUDIO_EFFECT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clock and masked during reset.
`define LPECHO_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on clock and masked during reset.
`define LPECHO_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LPECHO_ASSERT_IMP(lbl, ante, cons, msg)
`define LPECHO_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/lpecho_pkg.sv
// Package with types, constants and saturation helpers of the lowpass echo effect.
`default_nettype none
package lpecho_pkg;

   // Storage sizing
   localparam int HISTORY_DEPTH = 8192;
   localparam int ACCUM_WIDTH   = 24;
   localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
   localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int HIST_W   = 24;
   localparam int MODE_W   = 3;
   localparam int SHIFT_W  = 4;
   localparam int RATIO_W  = 7;
   localparam int DELAY_W  = 13;

   // Compare and pointer arithmetic widths
   localparam int CMP_W = (FILL_W > DELAY_W) ? FILL_W : DELAY_W;
   localparam int RP_W  = CMP_W + 1;

   // Echo gain datapath: |history| * ratio, then divide by the percent base
   localparam int PERCENT     = 100;
   localparam int MAG_W       = HIST_W - 1 + RATIO_W;
   localparam int QEST_W      = MAG_W - 6;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 26;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / PERCENT);
   localparam int REM_W       = MAG_W + 1;

   // Sum and saturation widths
   localparam int ACC_EXT_W = ACCUM_WIDTH + 2;
   localparam int SUM_W     = HIST_W + 2;
   localparam int WIDE_W    = 34;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;
   localparam logic [REG_IDX_W-1:0] REG_MODE  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHIFT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_RATIO = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_DELAY = 2'd3;

   // Register reset values
   localparam logic [MODE_W-1:0]  RST_MODE  = 3'd0;
   localparam logic [SHIFT_W-1:0] RST_SHIFT = 4'd4;
   localparam logic [RATIO_W-1:0] RST_RATIO = 7'd25;
   localparam logic [DELAY_W-1:0] RST_DELAY = 13'd4410;

   // Effect modes
   localparam logic [MODE_W-1:0] MODE_BYPASS  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOWPASS = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LP_ECHO = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FB_ECHO = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FF_ECHO = 3'd4;

   typedef logic signed [SAMPLE_W-1:0]    sample_type;
   typedef logic signed [HIST_W-1:0]      hist_type;
   typedef logic signed [ACCUM_WIDTH-1:0] acc_type;
   typedef logic signed [WIDE_W-1:0]      wide_type;

   // Per-request pipeline payload
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              dt_en;
      logic              wen;
      logic [ADDR_W-1:0] waddr;
      sample_type        base;
      sample_type        x;
   } stage_type;

   // Saturation limits
   localparam wide_type S16_MAX = (WIDE_W'(1) <<< (SAMPLE_W - 1)) - WIDE_W'(1);
   localparam wide_type S16_MIN = -S16_MAX - WIDE_W'(1);
   localparam wide_type S24_MAX = (WIDE_W'(1) <<< (HIST_W - 1)) - WIDE_W'(1);
   localparam wide_type S24_MIN = -S24_MAX - WIDE_W'(1);
   localparam wide_type ACC_MAX = (WIDE_W'(1) <<< (ACCUM_WIDTH - 1)) - WIDE_W'(1);
   localparam wide_type ACC_MIN = -ACC_MAX - WIDE_W'(1);

   function automatic sample_type sat16(input wide_type v);
      sample_type r;
      if (v > S16_MAX) r = SAMPLE_W'(S16_MAX);
      else if (v < S16_MIN) r = SAMPLE_W'(S16_MIN);
      else r = SAMPLE_W'(v);
      return r;
   endfunction

   function automatic hist_type sat24(input wide_type v);
      hist_type r;
      if (v > S24_MAX) r = HIST_W'(S24_MAX);
      else if (v < S24_MIN) r = HIST_W'(S24_MIN);
      else r = HIST_W'(v);
      return r;
   endfunction

   function automatic acc_type sat_acc(input wide_type v);
      acc_type r;
      if (v > ACC_MAX) r = ACCUM_WIDTH'(ACC_MAX);
      else if (v < ACC_MIN) r = ACCUM_WIDTH'(ACC_MIN);
      else r = ACCUM_WIDTH'(v);
      return r;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lpecho_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module lpecho_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register read data; hold it between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/lowpass_echo_audio_effect.sv
// Top level of the stereo one-pole lowpass and comb echo effect.
// Usage:
//   Requests (req_sample_in, req_channel, req_start_of_sound) enter on a
//   valid/ready channel; each request yields one rsp_sample_out on the rsp
//   valid/ready channel, in order. The user must write registers through the
//   APB port only while the block is idle, which the block does not enforce;
//   pready is tied high. Pipeline: a taken request goes through the history
//   read with gain multiply, the reciprocal multiply, then correction and sum
//   into the output register together with the history write.
// Throughput: one request per cycle while results are taken without stalls.
//   When an echo read hits an entry still being computed by a request in flight
//   (a delay register value of 1 to 3 while an echo mode is on), intake waits
//   until that entry is written.
// Reset: synchronous; clears the pipeline, accumulators, write pointer and
//   fill count and loads register defaults. History needs no clearing pass:
//   the fill count keeps entries that were never written from being read.
// Stall: a held result sits in the output register; stages behind it keep
//   filling until every stage is occupied, then intake stops.
`default_nettype none
`include "lowpass_echo_audio_effect_assert.svh"
module lowpass_echo_audio_effect
   import lpecho_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   input  wire logic                  req_channel,
   input  wire logic                  req_start_of_sound,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // Configuration registers
   logic [MODE_W-1:0]  cfg_mode_ff, cfg_mode_in;
   logic [SHIFT_W-1:0] cfg_shift_ff, cfg_shift_in;
   logic [RATIO_W-1:0] cfg_ratio_ff, cfg_ratio_in;
   logic [DELAY_W-1:0] cfg_delay_ff, cfg_delay_in;
   logic               csr_wr;

   // Effect state outside the history memory
   acc_type           acc_ff [2];
   acc_type           acc_in [2];
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   // Pipeline stages
   logic              v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   stage_type         s1_ff, s1_in, s2_ff, s2_in, s3_ff, s3_in;
   logic [MAG_W-1:0]  s2_mag_ff, s2_mag_in, s3_mag_ff, s3_mag_in;
   logic              s2_neg_ff, s2_neg_in, s3_neg_ff, s3_neg_in;
   logic [QEST_W-1:0] s3_q_ff, s3_q_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sample_type        rsp_data_ff, rsp_data_in;

   // Flow control
   logic go1, go2, go3, free1, free2, free3, req_fire, hazard;

   // Intake stage signals
   logic [FILL_W-1:0]      fill_eff;
   logic [ADDR_W-1:0]      wp_eff;
   logic                   echo_s0, lp_s0, dt_en_s0;
   logic [CMP_W-1:0]       dly_cmp, fill_cmp;
   logic [RP_W-1:0]        wp_x, dly_x, rp_full;
   logic [ADDR_W-1:0]      rp;
   acc_type                acc_cur, y_full, acc_new;
   logic signed [ACC_EXT_W-1:0] acc_sum;
   sample_type             lp_y;

   // Memory and later stages
   logic [HIST_W-1:0]      ram_q;
   logic [HIST_W-1:0]      hist_wdata;
   logic                   ram_wen;
   logic [HIST_W-1:0]      hist_mag;
   logic [MAG_W:0]         gain_prod;
   logic [MAG_W+RECIP_W-1:0] recip_prod;
   logic [REM_W-1:0]       rem;
   logic [QEST_W-1:0]      q_fix;
   logic signed [SUM_W-1:0] dterm, sum;
   sample_type             y_out;

   // Register writes and reads
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_mode_in  = cfg_mode_ff;
      cfg_shift_in = cfg_shift_ff;
      cfg_ratio_in = cfg_ratio_ff;
      cfg_delay_in = cfg_delay_ff;
      if (csr_wr) begin
         case (paddr[CSR_ADDR_W-1:2])
            REG_MODE:  cfg_mode_in  = pwdata[MODE_W-1:0];
            REG_SHIFT: cfg_shift_in = pwdata[SHIFT_W-1:0];
            REG_RATIO: cfg_ratio_in = pwdata[RATIO_W-1:0];
            REG_DELAY: cfg_delay_in = pwdata[DELAY_W-1:0];
            default:   cfg_mode_in  = cfg_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[CSR_ADDR_W-1:2])
         REG_MODE:  prdata = CSR_DATA_W'(cfg_mode_ff);
         REG_SHIFT: prdata = CSR_DATA_W'(cfg_shift_ff);
         REG_RATIO: prdata = CSR_DATA_W'(cfg_ratio_ff);
         REG_DELAY: prdata = CSR_DATA_W'(cfg_delay_ff);
         default:   prdata = '0;
      endcase
   end

   // Stage advance: each stage moves when the one ahead is free
   assign go3   = v3_ff && (!rsp_valid_ff || rsp_ready);
   assign free3 = !v3_ff || go3;
   assign go2   = v2_ff && free3;
   assign free2 = !v2_ff || go2;
   assign go1   = v1_ff && free2;
   assign free1 = !v1_ff || go1;

   // A start request clears pointer and fill before its own read
   assign fill_eff = req_start_of_sound ? '0 : fill_ff;
   assign wp_eff   = req_start_of_sound ? '0 : wp_ff;

   always_comb begin
      echo_s0  = cfg_mode_ff inside {MODE_LP_ECHO, MODE_FB_ECHO, MODE_FF_ECHO};
      lp_s0    = cfg_mode_ff inside {MODE_LOWPASS, MODE_LP_ECHO};
      dly_cmp  = CMP_W'(cfg_delay_ff);
      fill_cmp = CMP_W'(fill_eff);
      dt_en_s0 = echo_s0 && (cfg_delay_ff != '0) &&
                 (dly_cmp <= CMP_W'(HISTORY_DEPTH)) && (fill_cmp >= dly_cmp);
      // Read position: delay entries behind the write pointer, wrapped
      wp_x  = RP_W'(wp_eff);
      dly_x = RP_W'(cfg_delay_ff);
      if (wp_x >= dly_x) rp_full = wp_x - dly_x;
      else rp_full = wp_x + RP_W'(HISTORY_DEPTH) - dly_x;
      rp = rp_full[ADDR_W-1:0];
   end

   // Interlock: hold the request while its entry is still in flight
   assign hazard = dt_en_s0 &&
      ((v1_ff && s1_ff.wen && (s1_ff.waddr == rp)) ||
       (v2_ff && s2_ff.wen && (s2_ff.waddr == rp)) ||
       (v3_ff && s3_ff.wen && (s3_ff.waddr == rp)));

   assign req_ready = free1 && !hazard;
   assign req_fire  = req_valid && req_ready;

   // Lowpass: output acc >>> shift, then fold in the input
   always_comb begin
      acc_cur = req_start_of_sound ? '0 : acc_ff[req_channel];
      y_full  = acc_cur >>> cfg_shift_ff;
      lp_y    = sat16(WIDE_W'(y_full));
      acc_sum = ACC_EXT_W'(acc_cur) - ACC_EXT_W'(y_full) + ACC_EXT_W'(req_sample_in);
      acc_new = sat_acc(WIDE_W'(acc_sum));
   end

   // Update accumulators, write pointer and fill count on intake
   always_comb begin
      acc_in[0] = acc_ff[0];
      acc_in[1] = acc_ff[1];
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      if (req_fire) begin
         if (req_start_of_sound) begin
            acc_in[0] = '0;
            acc_in[1] = '0;
         end
         if (lp_s0) begin
            acc_in[req_channel] = acc_new;
         end
         wp_in   = wp_eff;
         fill_in = fill_eff;
         if (echo_s0) begin
            wp_in = (wp_eff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_eff + 1'b1;
            if (fill_eff < FILL_W'(HISTORY_DEPTH)) fill_in = fill_eff + 1'b1;
         end
      end
   end

   // Advance stage one from intake
   always_comb begin
      v1_in = free1 ? req_fire : v1_ff;
      s1_in = s1_ff;
      if (req_fire) begin
         s1_in.mode  = cfg_mode_ff;
         s1_in.dt_en = dt_en_s0;
         s1_in.wen   = echo_s0;
         s1_in.waddr = wp_eff;
         s1_in.base  = lp_s0 ? lp_y : req_sample_in;
         s1_in.x     = req_sample_in;
      end
   end

   // History memory: one read on intake, one write as stage three retires
   lpecho_ram #(
      .WIDTH(HIST_W),
      .DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (s3_ff.waddr),
      .wr_data (hist_wdata),
      .rd_en   (req_fire && dt_en_s0),
      .rd_addr (rp),
      .rd_data (ram_q)
   );

   // Stage one: magnitude of the delayed entry times the ratio
   always_comb begin
      if (!s1_ff.dt_en) hist_mag = '0;
      else if (ram_q[HIST_W-1]) hist_mag = ~ram_q + 1'b1;
      else hist_mag = ram_q;
      gain_prod = (MAG_W + 1)'(hist_mag) * (MAG_W + 1)'(cfg_ratio_ff);
      v2_in     = free2 ? go1 : v2_ff;
      s2_in     = go1 ? s1_ff : s2_ff;
      s2_mag_in = go1 ? MAG_W'(gain_prod) : s2_mag_ff;
      s2_neg_in = go1 ? (s1_ff.dt_en && ram_q[HIST_W-1]) : s2_neg_ff;
   end

   // Stage two: quotient estimate by reciprocal multiply, low by at most one
   always_comb begin
      recip_prod = (MAG_W + RECIP_W)'(s2_mag_ff) * (MAG_W + RECIP_W)'(RECIP);
      v3_in      = free3 ? go2 : v3_ff;
      s3_in      = go2 ? s2_ff : s3_ff;
      s3_mag_in  = go2 ? s2_mag_ff : s3_mag_ff;
      s3_neg_in  = go2 ? s2_neg_ff : s3_neg_ff;
      s3_q_in    = go2 ? recip_prod[RECIP_SHIFT +: QEST_W] : s3_q_ff;
   end

   // Stage three: correct quotient, restore sign, add, clamp, pick history value
   always_comb begin
      rem   = REM_W'(s3_mag_ff) - REM_W'(s3_q_ff) * REM_W'(PERCENT);
      q_fix = (rem >= REM_W'(PERCENT)) ? s3_q_ff + 1'b1 : s3_q_ff;
      dterm = $signed(SUM_W'(q_fix));
      if (s3_neg_ff) dterm = -dterm;
      sum   = SUM_W'($signed(s3_ff.base)) + dterm;
      y_out = sat16(WIDE_W'(sum));
      case (s3_ff.mode)
         MODE_LP_ECHO: hist_wdata = HIST_W'(y_out);
         MODE_FB_ECHO: hist_wdata = sat24(WIDE_W'(sum));
         default:      hist_wdata = HIST_W'($signed(s3_ff.x));
      endcase
   end

   assign ram_wen = go3 && s3_ff.wen;

   // Output register: load from stage three, drop once taken
   always_comb begin
      if (go3) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
      rsp_data_in = go3 ? y_out : rsp_data_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff  <= RST_MODE;
         cfg_shift_ff <= RST_SHIFT;
         cfg_ratio_ff <= RST_RATIO;
         cfg_delay_ff <= RST_DELAY;
         acc_ff[0]    <= '0;
         acc_ff[1]    <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_mode_ff  <= cfg_mode_in;
         cfg_shift_ff <= cfg_shift_in;
         cfg_ratio_ff <= cfg_ratio_in;
         cfg_delay_ff <= cfg_delay_in;
         acc_ff[0]    <= acc_in[0];
         acc_ff[1]    <= acc_in[1];
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      s2_mag_ff   <= s2_mag_in;
      s3_mag_ff   <= s3_mag_in;
      s2_neg_ff   <= s2_neg_in;
      s3_neg_ff   <= s3_neg_in;
      s3_q_ff     <= s3_q_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks
   `LPECHO_ASSERT_IMP(a_s1_from_intake, $rose(v1_ff), $past(req_fire),
      "stage one filled without an accepted request")
   `LPECHO_ASSERT_IMP(a_rsp_from_s3, $rose(rsp_valid_ff), $past(v3_ff),
      "result shown without a request in stage three")
   `LPECHO_ASSERT_NXT(a_wp_hold, !req_fire, $stable(wp_ff),
      "write pointer moved without an accepted request")
   `LPECHO_ASSERT_NXT(a_write_to_rsp, ram_wen, rsp_valid_ff,
      "history written without a result being loaded")

endmodule
`default_nettype wire
